FILE: hw/rtl/svse_pkg.sv
// ============================================================================
// svse_pkg
// Types, widths, codes and helper functions shared by the silhouette
// extruder modules.
// ============================================================================
`default_nettype none

package svse_pkg;

   localparam int COORD_W = 24;
   localparam int VTX_W   = 72;
   localparam int IDX_W   = 12;
   localparam int NB_W    = 13;
   localparam int LXY_W   = 16;
   localparam int LZ_W    = 15;
   localparam int EDGE_W  = 25;
   localparam int NRM_W   = 51;
   localparam int SPLIT_W = 20;
   localparam int ACC_W   = 70;
   localparam int MA_W    = 33;
   localparam int MB_W    = 26;
   localparam int PROD_W  = 59;
   localparam int QUO_W   = 41;
   localparam int DEN_W   = 15;
   localparam int SUM_W   = 42;
   localparam int REQ_W   = 160;

   typedef enum logic [1:0] {
      CMD_LOAD     = 2'd0,
      CMD_CLASSIFY = 2'd1,
      CMD_EMIT     = 2'd2
   } cmd_type;

   localparam logic [1:0] CSR_LIGHT_X = 2'd0;
   localparam logic [1:0] CSR_LIGHT_Y = 2'd1;
   localparam logic [1:0] CSR_LIGHT_Z = 2'd2;
   localparam logic [1:0] CSR_GROUND  = 2'd3;

   typedef enum logic [2:0] {
      MUL_CROSS_P,
      MUL_CROSS_M,
      MUL_DOT_LO,
      MUL_DOT_HI,
      MUL_EXT
   } mul_kind_type;

   typedef enum logic [2:0] {
      SRC_ZERO,
      SRC_A,
      SRC_FA,
      SRC_B,
      SRC_FB
   } src_type;

   typedef struct packed {
      logic         capture;
      logic         vrd_en;
      logic [1:0]   vrd_corner;
      logic [1:0]   vrd_dst;
      logic         frd_en;
      logic         frd_self;
      logic [1:0]   frd_k;
      logic         e_load;
      logic         mul_en;
      mul_kind_type mul_kind;
      logic [1:0]   mul_k;
      logic         acc_en;
      logic         acc_clr;
      logic         acc_sub;
      logic         acc_shift;
      logic         n_wr;
      logic         vb;
      logic         div_start;
      logic         far_wr;
      logic         far_comp;
      logic         flag_wr;
      logic         push;
      logic         push_cls;
      src_type      src;
      logic         last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       face;
      logic [2:0] sil;
      logic       div_busy;
      logic       div_done;
      logic       out_free;
   } dp_status_type;

   function automatic logic signed [COORD_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
      if (v > 42'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (v < -42'sd8388608) begin
         return 24'sh800000;
      end else begin
         return v[COORD_W-1:0];
      end
   endfunction

   function automatic logic [1:0] next_corner(input logic [1:0] k);
      case (k)
         2'd0: begin
            return 2'd1;
         end
         2'd1: begin
            return 2'd2;
         end
         default: begin
            return 2'd0;
         end
      endcase
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/shadow_volume_silhouette_extruder.sv
// ============================================================================
// shadow_volume_silhouette_extruder
// Classifies triangles against a directional light and extrudes silhouette
// edges into shadow-volume side quads.
// ============================================================================
//
// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   tuser: command; tdata: item fields
// rsp      out        rsp_tvalid/rsp_tready   tuser: faces_light; tdata: x,y,z;
//                                             tlast: last
// csr      in         csr_wr_en               csr_index, csr_wr_data
//
// A load item is done as it is accepted. A classify item makes the twelve
// passes through the shared multiplier. An emit item does the capture and flag
// reads, then four divisions in the extrusion divider per silhouette edge.
// Reset is synchronous, clears control state and sets the light and ground
// registers to defaults; the stores hold undefined data until written.
// A stalled result port holds the sequencer.
// ============================================================================
`default_nettype none

module shadow_volume_silhouette_extruder import svse_pkg::*; #(
   parameter int VERTEX_DEPTH   = 4096,
   parameter int TRIANGLE_DEPTH = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // command
   input  logic [1:0]         req_tuser,
   // item_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c,
   // neighbor_ab, neighbor_bc, neighbor_ca, one zero pad bit
   input  logic [REQ_W-1:0]   req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // out_x, out_y, out_z
   output logic [VTX_W-1:0]   rsp_tdata,
   // faces_light
   output logic               rsp_tuser,
   output logic               rsp_tlast,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [COORD_W-1:0] csr_wr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   svse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

   svse_dp #(
      .VERTEX_DEPTH   (VERTEX_DEPTH),
      .TRIANGLE_DEPTH (TRIANGLE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   a_face_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("classify result without last or with nonzero vertex");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !stat.div_busy)
      else $error("divider started while busy");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> $past(stat.div_busy))
      else $error("divider done without a running division");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> stat.out_free)
      else $error("result pushed into a full output register");

endmodule

`default_nettype wire

FILE: hw/rtl/svse_ram.sv
// ============================================================================
// svse_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module svse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/svse_div.sv
// ============================================================================
// svse_div
// Restoring divider, one quotient bit per cycle. Divides a signed product by
// the negated light z (one if z >= 0), rounding to nearest, ties away from zero.
// ============================================================================
`default_nettype none

module svse_div import svse_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [QUO_W-1:0] numer,
   input  logic signed [LZ_W-1:0]  light_z,
   output logic                    busy,
   output logic                    done,
   output logic signed [QUO_W-1:0] quot
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic                busy_ff;
   logic                done_ff;
   logic                neg_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [DEN_W-1:0]    rem_ff;
   logic [QUO_W-1:0]    q_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [QUO_W-1:0]    mag;
   logic [DEN_W-1:0]    den_in;
   logic [DEN_W:0]      neg_lz;
   logic [DEN_W:0]      trial;
   logic                ge;

   always_comb begin
      mag    = numer[QUO_W-1] ? (QUO_W)'(-numer) : numer;
      neg_lz = -{light_z[LZ_W-1], light_z};
      den_in = light_z[LZ_W-1] ? neg_lz[DEN_W-1:0] : DEN_W'(1);
      trial  = {rem_ff, q_ff[QUO_W-1]};
      ge     = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUO_W);
            neg_ff  <= numer[QUO_W-1];
            den_ff  <= den_in;
            rem_ff  <= '0;
            q_ff    <= mag + QUO_W'(den_in >> 1);
         end else if (busy_ff) begin
            rem_ff <= ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            q_ff   <= {q_ff[QUO_W-2:0], ge};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = neg_ff ? -$signed(q_ff) : $signed(q_ff);

endmodule

`default_nettype wire

FILE: hw/rtl/svse_ctrl.sv
// ============================================================================
// svse_ctrl
// Sequencer for load, classify and emit items. Drives the datapath through
// one command word per cycle.
// ============================================================================
`default_nettype none

module svse_ctrl import svse_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,
   output ctrl_cmd_type  cmd,
   input  dp_status_type stat
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CL_FETCH,
      ST_CL_WAIT,
      ST_CL_EDGE,
      ST_CL_CROSS,
      ST_CL_DOT,
      ST_CL_WAIT2,
      ST_CL_OUT,
      ST_EM_FLAG,
      ST_EM_WAIT,
      ST_EM_CHECK,
      ST_EM_FETCH,
      ST_EM_FWAIT,
      ST_EX_MUL,
      ST_EX_DSTART,
      ST_EX_DWAIT,
      ST_EM_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [1:0] k_ff, k_in;
   logic       vsel_ff, vsel_in;
   logic       comp_ff, comp_in;
   logic       more;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         k_ff     <= '0;
         vsel_ff  <= 1'b0;
         comp_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         k_ff     <= k_in;
         vsel_ff  <= vsel_in;
         comp_ff  <= comp_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      k_in       = k_ff;
      vsel_in    = vsel_ff;
      comp_in    = comp_ff;
      cmd        = '0;
      req_tready = 1'b0;
      more       = ((k_ff == 2'd0) && (stat.sil[1] || stat.sil[2])) ||
                   ((k_ff == 2'd1) && stat.sil[2]);
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            step_in    = '0;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               case (cmd_type'(req_tuser))
                  CMD_CLASSIFY: begin
                     state_in = ST_CL_FETCH;
                  end
                  CMD_EMIT: begin
                     state_in = ST_EM_FLAG;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CL_FETCH: begin
            cmd.vrd_en     = 1'b1;
            cmd.vrd_corner = step_ff[1:0];
            cmd.vrd_dst    = step_ff[1:0];
            step_in        = step_ff + 3'd1;
            if (step_ff == 3'd2) begin
               state_in = ST_CL_WAIT;
               step_in  = '0;
            end
         end
         ST_CL_WAIT: begin
            state_in = ST_CL_EDGE;
         end
         ST_CL_EDGE: begin
            cmd.e_load = 1'b1;
            state_in   = ST_CL_CROSS;
         end
         ST_CL_CROSS: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_kind = step_ff[0] ? MUL_CROSS_M : MUL_CROSS_P;
            cmd.mul_k    = step_ff[2:1];
            cmd.acc_en   = 1'b1;
            cmd.acc_clr  = !step_ff[0];
            cmd.acc_sub  = step_ff[0];
            cmd.n_wr     = step_ff[0];
            step_in      = step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               state_in = ST_CL_DOT;
               step_in  = '0;
            end
         end
         ST_CL_DOT: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_kind  = step_ff[0] ? MUL_DOT_HI : MUL_DOT_LO;
            cmd.mul_k     = step_ff[2:1];
            cmd.acc_en    = 1'b1;
            cmd.acc_clr   = (step_ff == 3'd0);
            cmd.acc_shift = step_ff[0];
            step_in       = step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               state_in = ST_CL_WAIT2;
               step_in  = '0;
            end
         end
         ST_CL_WAIT2: begin
            state_in = ST_CL_OUT;
         end
         ST_CL_OUT: begin
            if (stat.out_free) begin
               cmd.push     = 1'b1;
               cmd.push_cls = 1'b1;
               cmd.src      = SRC_ZERO;
               cmd.last     = 1'b1;
               cmd.flag_wr  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EM_FLAG: begin
            cmd.frd_en   = 1'b1;
            cmd.frd_self = (step_ff == 3'd0);
            cmd.frd_k    = step_ff[1:0] - 2'd1;
            step_in      = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               state_in = ST_EM_WAIT;
               step_in  = '0;
            end
         end
         ST_EM_WAIT: begin
            state_in = ST_EM_CHECK;
         end
         ST_EM_CHECK: begin
            if (stat.face && (stat.sil != 3'b000)) begin
               k_in     = stat.sil[0] ? 2'd0 : (stat.sil[1] ? 2'd1 : 2'd2);
               state_in = ST_EM_FETCH;
               step_in  = '0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EM_FETCH: begin
            cmd.vrd_en     = 1'b1;
            cmd.vrd_corner = step_ff[0] ? next_corner(k_ff) : k_ff;
            cmd.vrd_dst    = {1'b0, step_ff[0]};
            step_in        = step_ff + 3'd1;
            if (step_ff[0]) begin
               state_in = ST_EM_FWAIT;
               step_in  = '0;
            end
         end
         ST_EM_FWAIT: begin
            vsel_in  = 1'b0;
            comp_in  = 1'b0;
            state_in = ST_EX_MUL;
         end
         ST_EX_MUL: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_kind = MUL_EXT;
            cmd.mul_k    = {1'b0, comp_ff};
            cmd.vb       = vsel_ff;
            state_in     = ST_EX_DSTART;
         end
         ST_EX_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_EX_DWAIT;
         end
         ST_EX_DWAIT: begin
            cmd.vb       = vsel_ff;
            cmd.far_comp = comp_ff;
            if (stat.div_done) begin
               cmd.far_wr = 1'b1;
               if (!comp_ff) begin
                  comp_in  = 1'b1;
                  state_in = ST_EX_MUL;
               end else if (!vsel_ff) begin
                  vsel_in  = 1'b1;
                  comp_in  = 1'b0;
                  state_in = ST_EX_MUL;
               end else begin
                  step_in  = '0;
                  state_in = ST_EM_OUT;
               end
            end
         end
         ST_EM_OUT: begin
            case (step_ff)
               3'd0: begin
                  cmd.src = SRC_A;
               end
               3'd1: begin
                  cmd.src = SRC_FA;
               end
               3'd2: begin
                  cmd.src = SRC_B;
               end
               3'd3: begin
                  cmd.src = SRC_B;
               end
               3'd4: begin
                  cmd.src = SRC_FA;
               end
               default: begin
                  cmd.src = SRC_FB;
               end
            endcase
            if (stat.out_free) begin
               cmd.push = 1'b1;
               cmd.last = (step_ff == 3'd5) && !more;
               step_in  = step_ff + 3'd1;
               if (step_ff == 3'd5) begin
                  step_in = '0;
                  if (more) begin
                     k_in     = ((k_ff == 2'd0) && stat.sil[1]) ? 2'd1 : 2'd2;
                     state_in = ST_EM_FETCH;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/svse_dp.sv
// ============================================================================
// svse_dp
// Datapath: configuration registers, vertex and facing-flag stores, shared
// multiplier and accumulator, extrusion divider and the result register.
// ============================================================================
`default_nettype none

module svse_dp import svse_pkg::*; #(
   parameter int VERTEX_DEPTH   = 4096,
   parameter int TRIANGLE_DEPTH = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      stat,
   input  logic [1:0]         req_tuser,
   input  logic [REQ_W-1:0]   req_tdata,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [COORD_W-1:0] csr_wr_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VTX_W-1:0]   rsp_tdata,
   output logic               rsp_tuser,
   output logic               rsp_tlast
);

   localparam int VAW = $clog2(VERTEX_DEPTH);
   localparam int TAW = $clog2(TRIANGLE_DEPTH);

   logic signed [LXY_W-1:0]   lx_ff, ly_ff;
   logic signed [LZ_W-1:0]    lz_ff;
   logic signed [COORD_W-1:0] gnd_ff;

   logic [IDX_W-1:0] idx_ff, ca_ff, cb_ff, cc_ff;
   logic [NB_W-1:0]  nb0_ff, nb1_ff, nb2_ff;

   logic [VTX_W-1:0] va_ff, vb_ff, vc_ff, fa_ff, fb_ff;
   logic [2:0][EDGE_W-1:0] e1_ff, e2_ff;
   logic [NRM_W-1:0] n0_ff, n1_ff, n2_ff;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, addend, base;
   logic       pend_ff, pclr_ff, psub_ff, pshift_ff, pnwr_ff;
   logic [1:0] pk_ff;

   logic             vpend_ff, vok_ff;
   logic [1:0]       vdst_ff;
   logic             fpend_ff, fok_ff, fself_ff;
   logic [1:0]       fk_ff;
   logic             face_ff;
   logic [2:0]       sil_ff;

   logic             rsp_valid_ff, rsp_user_ff, rsp_last_ff;
   logic [VTX_W-1:0] rsp_data_ff;

   logic [IDX_W-1:0]  in_idx, csel;
   logic [NB_W-1:0]   nbsel;
   logic [IDX_W-1:0]  faddr;
   logic              in_vok, c_ok, f_ok, idx_tok, out_free, dot_le0;
   logic              v_wr_en;
   logic [VTX_W-1:0]  v_rd_data;
   logic [0:0]        f_rd_data;

   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic [NRM_W-1:0]          nsel;
   logic signed [LXY_W-1:0]   lsel;
   logic [VTX_W-1:0]          vsel;
   logic signed [COORD_W-1:0] vx, vy, vz, m, vc_sel;
   logic signed [QUO_W-1:0]   quot;
   logic                      div_busy, div_done;
   logic signed [COORD_W-1:0] far_c, far_z;
   logic [VTX_W-1:0]          out_sel;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         lx_ff  <= -16'sd11583;
         ly_ff  <= 16'sd347;
         lz_ff  <= -15'sd11583;
         gnd_ff <= 24'sd5760;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LIGHT_X: begin
               lx_ff <= csr_wr_data[LXY_W-1:0];
            end
            CSR_LIGHT_Y: begin
               ly_ff <= csr_wr_data[LXY_W-1:0];
            end
            CSR_LIGHT_Z: begin
               lz_ff <= csr_wr_data[LZ_W-1:0];
            end
            default: begin
               gnd_ff <= csr_wr_data;
            end
         endcase
      end
   end

   assign in_idx  = req_tdata[11:0];
   assign in_vok  = 32'(in_idx) < VERTEX_DEPTH;
   assign v_wr_en = cmd.capture && (req_tuser == CMD_LOAD) && in_vok;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff <= in_idx;
         ca_ff  <= req_tdata[95:84];
         cb_ff  <= req_tdata[107:96];
         cc_ff  <= req_tdata[119:108];
         nb0_ff <= req_tdata[132:120];
         nb1_ff <= req_tdata[145:133];
         nb2_ff <= req_tdata[158:146];
      end
   end

   always_comb begin
      case (cmd.vrd_corner)
         2'd0: begin
            csel = ca_ff;
         end
         2'd1: begin
            csel = cb_ff;
         end
         default: begin
            csel = cc_ff;
         end
      endcase
      case (cmd.frd_k)
         2'd0: begin
            nbsel = nb0_ff;
         end
         2'd1: begin
            nbsel = nb1_ff;
         end
         default: begin
            nbsel = nb2_ff;
         end
      endcase
      c_ok    = 32'(csel) < VERTEX_DEPTH;
      idx_tok = 32'(idx_ff) < TRIANGLE_DEPTH;
      faddr   = cmd.frd_self ? idx_ff : nbsel[IDX_W-1:0];
      f_ok    = cmd.frd_self ? idx_tok
                             : (!nbsel[NB_W-1] && (32'(nbsel[IDX_W-1:0]) < TRIANGLE_DEPTH));
   end

   svse_ram #(
      .WIDTH (VTX_W),
      .DEPTH (VERTEX_DEPTH)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (VAW'(in_idx)),
      .wr_data (req_tdata[83:12]),
      .rd_addr (VAW'(csel)),
      .rd_data (v_rd_data)
   );

   svse_ram #(
      .WIDTH (1),
      .DEPTH (TRIANGLE_DEPTH)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (cmd.flag_wr && idx_tok),
      .wr_addr (TAW'(idx_ff)),
      .wr_data (dot_le0),
      .rd_addr (TAW'(faddr)),
      .rd_data (f_rd_data)
   );

   // Read tags and flag results.
   always_ff @(posedge clock) begin
      if (reset) begin
         vpend_ff <= 1'b0;
         fpend_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         vpend_ff <= cmd.vrd_en;
         fpend_ff <= cmd.frd_en;
         pend_ff  <= cmd.mul_en && cmd.acc_en;
      end
   end

   always_ff @(posedge clock) begin
      vdst_ff  <= cmd.vrd_dst;
      vok_ff   <= c_ok;
      fself_ff <= cmd.frd_self;
      fk_ff    <= cmd.frd_k;
      fok_ff   <= f_ok;
      if (vpend_ff) begin
         case (vdst_ff)
            2'd0: begin
               va_ff <= vok_ff ? v_rd_data : '0;
            end
            2'd1: begin
               vb_ff <= vok_ff ? v_rd_data : '0;
            end
            default: begin
               vc_ff <= vok_ff ? v_rd_data : '0;
            end
         endcase
      end
      if (fpend_ff) begin
         if (fself_ff) begin
            face_ff <= fok_ff && f_rd_data[0];
         end else begin
            sil_ff[fk_ff] <= !(fok_ff && f_rd_data[0]);
         end
      end
      if (cmd.e_load) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= EDGE_W'($signed(vb_ff[i*COORD_W +: COORD_W]))
                      - EDGE_W'($signed(va_ff[i*COORD_W +: COORD_W]));
            e2_ff[i] <= EDGE_W'($signed(vc_ff[i*COORD_W +: COORD_W]))
                      - EDGE_W'($signed(va_ff[i*COORD_W +: COORD_W]));
         end
      end
   end

   // Multiplier operand selection.
   always_comb begin
      vsel = cmd.vb ? vb_ff : va_ff;
      vx   = vsel[23:0];
      vy   = vsel[47:24];
      vz   = vsel[71:48];
      m    = (vz > gnd_ff) ? vz : gnd_ff;
      case (cmd.mul_k)
         2'd0: begin
            nsel = n0_ff;
            lsel = lx_ff;
         end
         2'd1: begin
            nsel = n1_ff;
            lsel = ly_ff;
         end
         default: begin
            nsel = n2_ff;
            lsel = LXY_W'(lz_ff);
         end
      endcase
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_kind)
         MUL_CROSS_P: begin
            case (cmd.mul_k)
               2'd0: begin
                  mul_a = MA_W'($signed(e1_ff[1]));
                  mul_b = MB_W'($signed(e2_ff[2]));
               end
               2'd1: begin
                  mul_a = MA_W'($signed(e1_ff[2]));
                  mul_b = MB_W'($signed(e2_ff[0]));
               end
               default: begin
                  mul_a = MA_W'($signed(e1_ff[0]));
                  mul_b = MB_W'($signed(e2_ff[1]));
               end
            endcase
         end
         MUL_CROSS_M: begin
            case (cmd.mul_k)
               2'd0: begin
                  mul_a = MA_W'($signed(e1_ff[2]));
                  mul_b = MB_W'($signed(e2_ff[1]));
               end
               2'd1: begin
                  mul_a = MA_W'($signed(e1_ff[0]));
                  mul_b = MB_W'($signed(e2_ff[2]));
               end
               default: begin
                  mul_a = MA_W'($signed(e1_ff[1]));
                  mul_b = MB_W'($signed(e2_ff[0]));
               end
            endcase
         end
         MUL_DOT_LO: begin
            mul_a = {{(MA_W-SPLIT_W){1'b0}}, nsel[SPLIT_W-1:0]};
            mul_b = MB_W'(lsel);
         end
         MUL_DOT_HI: begin
            mul_a = MA_W'($signed(nsel[NRM_W-1:SPLIT_W]));
            mul_b = MB_W'(lsel);
         end
         MUL_EXT: begin
            mul_a = MA_W'(m);
            mul_b = cmd.mul_k[0] ? MB_W'(ly_ff) : MB_W'(lx_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      addend = ACC_W'(prod_ff);
      if (pshift_ff) begin
         addend = addend <<< SPLIT_W;
      end
      base   = pclr_ff ? '0 : acc_ff;
      acc_in = psub_ff ? base - addend : base + addend;
   end

   assign dot_le0 = acc_ff[ACC_W-1] || (acc_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff   <= prod_in;
         pclr_ff   <= cmd.acc_clr;
         psub_ff   <= cmd.acc_sub;
         pshift_ff <= cmd.acc_shift;
         pnwr_ff   <= cmd.n_wr;
         pk_ff     <= cmd.mul_k;
      end
      if (pend_ff) begin
         acc_ff <= acc_in;
         if (pnwr_ff) begin
            case (pk_ff)
               2'd0: begin
                  n0_ff <= acc_in[NRM_W-1:0];
               end
               2'd1: begin
                  n1_ff <= acc_in[NRM_W-1:0];
               end
               default: begin
                  n2_ff <= acc_in[NRM_W-1:0];
               end
            endcase
         end
      end
   end

   svse_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .numer   (prod_ff[QUO_W-1:0]),
      .light_z (lz_ff),
      .busy    (div_busy),
      .done    (div_done),
      .quot    (quot)
   );

   // Far vertex: the z offset is exactly -m, x and y come from the divider.
   always_comb begin
      vc_sel = cmd.far_comp ? vy : vx;
      far_c  = sat24(SUM_W'(vc_sel) + SUM_W'(quot));
      far_z  = sat24(SUM_W'(vz) - SUM_W'(m));
   end

   always_ff @(posedge clock) begin
      if (cmd.far_wr) begin
         if (cmd.vb) begin
            if (cmd.far_comp) begin
               fb_ff[47:24] <= far_c;
            end else begin
               fb_ff[23:0]  <= far_c;
               fb_ff[71:48] <= far_z;
            end
         end else begin
            if (cmd.far_comp) begin
               fa_ff[47:24] <= far_c;
            end else begin
               fa_ff[23:0]  <= far_c;
               fa_ff[71:48] <= far_z;
            end
         end
      end
   end

   // Result register.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (cmd.src)
         SRC_A: begin
            out_sel = va_ff;
         end
         SRC_FA: begin
            out_sel = fa_ff;
         end
         SRC_B: begin
            out_sel = vb_ff;
         end
         SRC_FB: begin
            out_sel = fb_ff;
         end
         default: begin
            out_sel = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.push) begin
         rsp_data_ff <= out_sel;
         rsp_user_ff <= cmd.push_cls && dot_le0;
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign stat.face     = face_ff;
   assign stat.sil      = sil_ff;
   assign stat.div_busy = div_busy;
   assign stat.div_done = div_done;
   assign stat.out_free = out_free;

endmodule

`default_nettype wire

FILE: tb/tb_shadow_volume_silhouette_extruder.sv
// ============================================================================
// Silhouette extruder testbench
// Loads small meshes into the vertex store, classifies their triangles against
// several light settings, emits silhouette quads and checks every result
// vertex against an in-bench predictor, under varied handshake idling.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tb_shadow_volume_silhouette_extruder;
   import svse_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [1:0] req_tuser = '0;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [VTX_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [COORD_W-1:0] csr_wr_data = '0;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic faces;
      logic last;
   } vertex_out_type;

   vertex_out_type expected_vertices[$];
   longint vx_mem[4096], vy_mem[4096], vz_mem[4096];
   bit facing_mem[4096];
   longint lx, ly, lz, ground;
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_rsp = 1'b0;
   int quiet_cycles = 0;

   shadow_volume_silhouette_extruder DUT (.*);

   always #6 clock = ~clock;

   function automatic longint sat_coord(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint div_round(longint p, longint d);
      longint q;
      q = ((p < 0 ? -p : p) + d / 2) / d;
      return p < 0 ? -q : q;
   endfunction

   function automatic vertex_out_type make_vertex(longint x, longint y, longint z);
      vertex_out_type r;
      r.x = x[23:0];
      r.y = y[23:0];
      r.z = z[23:0];
      r.faces = 1'b0;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic extrude_point(input longint v[3], output longint f[3]);
      longint d, m, lzz;
      lzz = (lz >= 0) ? -1 : lz;
      d = -lzz;
      m = (v[2] > ground) ? v[2] : ground;
      f[0] = sat_coord(v[0] + div_round(m * lx, d));
      f[1] = sat_coord(v[1] + div_round(m * ly, d));
      f[2] = sat_coord(v[2] + div_round(m * lzz, d));
   endtask

   task automatic predict_item(input logic [1:0] cmd, input int idx, input int cr[3],
                               input int nb[3], input longint cx, input longint cy,
                               input longint cz);
      longint e1[3], e2[3], n[3], a[3], b[3], fa[3], fb[3];
      logic signed [80:0] dot;
      vertex_out_type r;
      bit face;
      int k, k2, first;
      if (cmd == CMD_LOAD) begin
         vx_mem[idx] = cx;
         vy_mem[idx] = cy;
         vz_mem[idx] = cz;
      end else if (cmd == CMD_CLASSIFY) begin
         e1[0] = vx_mem[cr[1]] - vx_mem[cr[0]];
         e1[1] = vy_mem[cr[1]] - vy_mem[cr[0]];
         e1[2] = vz_mem[cr[1]] - vz_mem[cr[0]];
         e2[0] = vx_mem[cr[2]] - vx_mem[cr[0]];
         e2[1] = vy_mem[cr[2]] - vy_mem[cr[0]];
         e2[2] = vz_mem[cr[2]] - vz_mem[cr[0]];
         n[0] = e1[1] * e2[2] - e1[2] * e2[1];
         n[1] = e1[2] * e2[0] - e1[0] * e2[2];
         n[2] = e1[0] * e2[1] - e1[1] * e2[0];
         dot = 81'(signed'(n[0])) * 81'(signed'(lx)) + 81'(signed'(n[1])) * 81'(signed'(ly))
             + 81'(signed'(n[2])) * 81'(signed'(lz));
         face = (dot <= 0);
         facing_mem[idx] = face;
         r = make_vertex(0, 0, 0);
         r.faces = face;
         r.last = 1'b1;
         expected_vertices.push_back(r);
      end else if (cmd == CMD_EMIT && facing_mem[idx]) begin
         first = expected_vertices.size();
         for (k = 0; k < 3; k++) begin
            if (nb[k] >= 0 && facing_mem[nb[k]]) continue;
            k2 = (k + 1) % 3;
            a[0] = vx_mem[cr[k]]; a[1] = vy_mem[cr[k]]; a[2] = vz_mem[cr[k]];
            b[0] = vx_mem[cr[k2]]; b[1] = vy_mem[cr[k2]]; b[2] = vz_mem[cr[k2]];
            extrude_point(a, fa);
            extrude_point(b, fb);
            expected_vertices.push_back(make_vertex(a[0], a[1], a[2]));
            expected_vertices.push_back(make_vertex(fa[0], fa[1], fa[2]));
            expected_vertices.push_back(make_vertex(b[0], b[1], b[2]));
            expected_vertices.push_back(make_vertex(b[0], b[1], b[2]));
            expected_vertices.push_back(make_vertex(fa[0], fa[1], fa[2]));
            expected_vertices.push_back(make_vertex(fb[0], fb[1], fb[2]));
         end
         if (expected_vertices.size() > first)
            expected_vertices[expected_vertices.size() - 1].last = 1'b1;
      end
   endtask

   // The valid stays up after an accepted item until the next item replaces it
   // or an idle phase drops it.
   task automatic send_item(input logic [1:0] cmd, input int idx, input int cr[3],
                            input int nb[3], input longint cx = 0, input longint cy = 0,
                            input longint cz = 0);
      logic [REQ_W-1:0] d;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      d = '0;
      d[11:0] = idx[11:0];
      d[35:12] = cx[23:0];
      d[59:36] = cy[23:0];
      d[83:60] = cz[23:0];
      d[95:84] = cr[0][11:0];
      d[107:96] = cr[1][11:0];
      d[119:108] = cr[2][11:0];
      d[132:120] = nb[0][12:0];
      d[145:133] = nb[1][12:0];
      d[158:146] = nb[2][12:0];
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(cmd, idx, cr, nb, cx, cy, cz);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (800) @(posedge clock);
   endtask

   task automatic write_light(input longint x, input longint y, input longint z,
                              input longint g);
      longint vals[4];
      int i;
      wait_idle();
      vals = '{x, y, z, g};
      for (i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= i[1:0];
         csr_wr_data <= vals[i][23:0];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      lx = x; ly = y; lz = z; ground = g;
   endtask

   function automatic longint rand_coord(bit wide);
      if (wide) return longint'($urandom_range(16777215)) - 8388608;
      return longint'($urandom_range(40000)) - 20000;
   endfunction

   // Loads a run of vertices at base_v and sends classify and emit items over a strip.
   task automatic run_mesh(input int base_v, input int base_t, input int tris,
                           input bit wide);
      int cr[3], nb[3];
      int i;
      for (i = 0; i < tris + 2; i++)
         send_item(CMD_LOAD, base_v + i, '{0, 0, 0}, '{0, 0, 0},
                   rand_coord(wide), rand_coord(wide), rand_coord(wide));
      for (i = 0; i < tris; i++) begin
         cr = '{base_v + i, base_v + i + 1, base_v + i + 2};
         send_item(CMD_CLASSIFY, base_t + i, cr, '{0, 0, 0});
      end
      for (i = 0; i < tris; i++) begin
         cr = '{base_v + i, base_v + i + 1, base_v + i + 2};
         nb[0] = (i > 0) ? base_t + i - 1 : -1;
         nb[1] = (i < tris - 1) ? base_t + i + 1 : -1;
         nb[2] = ($urandom_range(3) == 0) ? -1 - $urandom_range(4095)
                                          : base_t + $urandom_range(tris - 1);
         send_item(CMD_EMIT, base_t + i, cr, nb);
      end
   endtask

   task automatic test_directed();
      int z3[3];
      z3 = '{0, 0, 0};
      lx = -11583; ly = 347; lz = -11583; ground = 5760;
      send_item(CMD_LOAD, 0, z3, z3, 8388607, -8388608, 8388607);
      send_item(CMD_LOAD, 4095, z3, z3, -8388608, 8388607, -8388608);
      send_item(CMD_LOAD, 1, z3, z3, 0, 0, 0);
      send_item(CMD_LOAD, 2, z3, z3, 256, 0, 0);
      send_item(CMD_LOAD, 3, z3, z3, 0, 256, 0);
      send_item(CMD_CLASSIFY, 0, '{1, 2, 3}, z3);
      send_item(CMD_CLASSIFY, 1, '{1, 3, 2}, z3);
      send_item(CMD_CLASSIFY, 4095, '{1, 1, 2}, z3);
      send_item(CMD_CLASSIFY, 2, '{0, 4095, 1}, z3);
      send_item(CMD_EMIT, 0, '{1, 2, 3}, '{-1, 1, -4096});
      send_item(CMD_EMIT, 1, '{1, 3, 2}, '{0, 4095, -1});
      send_item(CMD_EMIT, 4095, '{1, 1, 2}, '{4095, 4095, 4095});
      send_item(CMD_EMIT, 2, '{0, 4095, 1}, '{-1, -1, -1});
      send_item(2'd3, 4095, '{4095, 4095, 4095}, '{-1, -1, -1}, -1, -1, -1);
      write_light(16384, -16384, -1, -8388608);
      send_item(CMD_CLASSIFY, 3, '{0, 4095, 1}, z3);
      send_item(CMD_EMIT, 3, '{0, 4095, 1}, '{-1, -1, -1});
      write_light(-16384, 16384, -16384, 8388607);
      send_item(CMD_CLASSIFY, 4, '{4095, 0, 2}, z3);
      send_item(CMD_EMIT, 4, '{4095, 0, 2}, '{-1, 4095, -1});
   endtask

   task automatic test_random();
      int m;
      for (m = 0; m < 14; m++) begin
         case (m % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 77; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 77; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         if (m % 3 == 0)
            write_light(longint'($urandom_range(32768)) - 16384,
                        longint'($urandom_range(32768)) - 16384,
                        -1 - longint'($urandom_range(16383)),
                        longint'($urandom_range(16777215)) - 8388608);
         run_mesh($urandom_range(4000), $urandom_range(4000), 3 + $urandom_range(3),
                  $urandom_range(3) == 0);
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_rsp = 1'b1;
      run_mesh(100, 200, 4, 1'b0);
      hold_rsp = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   // Long hold-off of the result port while items keep arriving.
   initial begin
      wait (hold_rsp);
      repeat (3000) @(posedge clock);
      hold_rsp = 1'b0;
   end

   always @(posedge clock) begin
      vertex_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_vertices.size() == 0) begin
            $error("unexpected result item");
            errors++;
         end else begin
            want = expected_vertices.pop_front();
            if (rsp_tdata[23:0] !== want.x) begin
               $error("out_x expected %0d got %0d", want.x, $signed(rsp_tdata[23:0]));
               errors++;
            end
            if (rsp_tdata[47:24] !== want.y) begin
               $error("out_y expected %0d got %0d", want.y, $signed(rsp_tdata[47:24]));
               errors++;
            end
            if (rsp_tdata[71:48] !== want.z) begin
               $error("out_z expected %0d got %0d", want.z, $signed(rsp_tdata[71:48]));
               errors++;
            end
            if (rsp_tuser !== want.faces) begin
               $error("faces_light expected %0d got %0d", want.faces, rsp_tuser);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last expected %0d got %0d", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      wait_idle();
      if (errors == 0 && expected_vertices.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: shadow_volume_silhouette_extruder.f
hw/rtl/svse_pkg.sv
hw/rtl/svse_ram.sv
hw/rtl/svse_div.sv
hw/rtl/svse_ctrl.sv
hw/rtl/svse_dp.sv
hw/rtl/shadow_volume_silhouette_extruder.sv
tb/tb_shadow_volume_silhouette_extruder.sv
